@@ design/pcm_pkg.sv @@
`default_nettype none

package pcm_pkg;

    localparam int RAMP_ENTRIES = 256;
    localparam int IDX_W        = $clog2(RAMP_ENTRIES);
    localparam int LAST_IDX     = RAMP_ENTRIES - 1;

    localparam int Z_W   = 32;
    localparam int DIF_W = Z_W + 1;
    localparam int NUM_W = DIF_W + IDX_W;

    // restoring steps: one saturation step plus one per index bit
    localparam int DIV_STAGES = IDX_W + 1;
    // input regs, abs, numerator, divider steps, ramp read, output
    localparam int PIPE_DEPTH = DIV_STAGES + 5;

    localparam logic [7:0] ALPHA_FULL = 8'hFF;

    typedef enum logic [1:0] {
        MODE_RGB,
        MODE_GREY,
        MODE_BWR,
        MODE_HEIGHT
    } color_mode_t;

    typedef enum logic [1:0] {
        RAMP_GREY,
        RAMP_BWR,
        RAMP_HEIGHT
    } ramp_sel_t;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_COLOR_MODE = 2'd0;
    localparam cfg_index_t CFG_Z_MIN      = 2'd1;
    localparam cfg_index_t CFG_Z_MAX      = 2'd2;

    localparam color_mode_t        MODE_RESET  = MODE_GREY;
    localparam logic signed [31:0] Z_MIN_RESET = 32'sd0;
    localparam logic signed [31:0] Z_MAX_RESET = 32'sd65536;

    typedef struct packed {
        logic signed [Z_W-1:0] z_coord;
        logic [7:0]            intensity;
        logic [7:0]            red_in;
        logic [7:0]            green_in;
        logic [7:0]            blue_in;
    } point_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } color_t;

    typedef struct packed {
        cfg_index_t  index;
        logic [31:0] value;
    } cfg_word_t;

    typedef struct packed {
        color_mode_t mode;
        logic [7:0]  intensity;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } side_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } ramp_rgb_t;

endpackage

`default_nettype wire

@@ design/pcm_stream_if.sv @@
`default_nettype none

interface pcm_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/pcm_height_div.sv @@
`default_nettype none

module pcm_height_div (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [pcm_pkg::Z_W-1:0] z_coord,
    input  wire logic signed [pcm_pkg::Z_W-1:0] z_min,
    input  wire logic signed [pcm_pkg::Z_W-1:0] z_max,
    input  wire pcm_pkg::side_t                side_in,
    output logic [pcm_pkg::IDX_W-1:0]          index,
    output pcm_pkg::side_t                     side_out
);
    import pcm_pkg::*;

    logic signed [DIF_W-1:0] d_a_reg, w_a_reg;
    side_t                   side_a_reg;

    logic [DIF_W-1:0] mag_d_b_reg, mag_w_b_reg;
    logic             zero_b_reg;
    side_t            side_b_reg;

    logic [NUM_W-1:0] num_c_reg;
    logic [DIF_W-1:0] den_c_reg;
    logic             zero_c_reg;
    side_t            side_c_reg;

    logic [NUM_W-1:0] rem_reg  [DIV_STAGES];
    logic [DIF_W-1:0] den_reg  [DIV_STAGES];
    logic [IDX_W:0]   q_reg    [DIV_STAGES];
    logic             zero_reg [DIV_STAGES];
    side_t            side_reg [DIV_STAGES];

    logic [NUM_W-1:0] rem_next [DIV_STAGES];
    logic [IDX_W:0]   q_next   [DIV_STAGES];

    logic [DIF_W-1:0] mag_d, mag_w;

    assign mag_d = d_a_reg[DIF_W-1] ? DIF_W'(-d_a_reg) : DIF_W'(d_a_reg);
    assign mag_w = w_a_reg[DIF_W-1] ? DIF_W'(-w_a_reg) : DIF_W'(w_a_reg);

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_step
        localparam int SHIFT = IDX_W - j;
        logic [NUM_W-1:0] rem_in;
        logic [DIF_W-1:0] den_in;
        logic [IDX_W:0]   q_in;
        logic [NUM_W-1:0] trial;

        if (j == 0)
        begin : g_first
            assign rem_in = num_c_reg;
            assign den_in = den_c_reg;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        assign trial = NUM_W'(den_in) << SHIFT;

        always_comb
        begin
            rem_next[j] = rem_in;
            q_next[j]   = q_in;
            if (rem_in >= trial)
            begin
                rem_next[j]      = rem_in - trial;
                q_next[j][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_a_reg    <= DIF_W'(z_coord) - DIF_W'(z_min);
            w_a_reg    <= DIF_W'(z_max) - DIF_W'(z_min);
            side_a_reg <= side_in;

            mag_d_b_reg <= mag_d;
            mag_w_b_reg <= mag_w;
            // empty range, or operands of opposite sign: quotient is at most zero
            zero_b_reg  <= (w_a_reg == '0) || (d_a_reg[DIF_W-1] != w_a_reg[DIF_W-1]);
            side_b_reg  <= side_a_reg;

            num_c_reg  <= {mag_d_b_reg, IDX_W'(0)} - NUM_W'(mag_d_b_reg);
            den_c_reg  <= mag_w_b_reg;
            zero_c_reg <= zero_b_reg;
            side_c_reg <= side_b_reg;

            for (int j = 0; j < DIV_STAGES; j++)
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
            end

            den_reg[0]  <= den_c_reg;
            zero_reg[0] <= zero_c_reg;
            side_reg[0] <= side_c_reg;
            for (int j = 1; j < DIV_STAGES; j++)
            begin
                den_reg[j]  <= den_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[DIV_STAGES-1])
            index = '0;
        else if (q_reg[DIV_STAGES-1][IDX_W])
            index = IDX_W'(LAST_IDX);
        else
            index = q_reg[DIV_STAGES-1][IDX_W-1:0];
    end

    assign side_out = side_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ design/pcm_ramp_rom.sv @@
`default_nettype none

module pcm_ramp_rom (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire pcm_pkg::ramp_sel_t       sel,
    input  wire logic [pcm_pkg::IDX_W-1:0] index,
    output pcm_pkg::ramp_rgb_t            rgb
);
    import pcm_pkg::*;

    // stop colours as {r, g, b} bits
    function automatic logic [2:0] stop_rgb(ramp_sel_t s, logic [1:0] n);
        logic [2:0] bits;
        bits = 3'b000;
        case (s)
            RAMP_GREY:
                bits = (n == 2'd1) ? 3'b111 : 3'b000;
            RAMP_BWR:
                case (n)
                    2'd0:    bits = 3'b001;
                    2'd1:    bits = 3'b111;
                    2'd2:    bits = 3'b100;
                    default: bits = 3'b000;
                endcase
            RAMP_HEIGHT:
                case (n)
                    2'd0:    bits = 3'b001;
                    2'd1:    bits = 3'b010;
                    2'd2:    bits = 3'b110;
                    default: bits = 3'b100;
                endcase
            default:
                bits = 3'b000;
        endcase
        return bits;
    endfunction

    function automatic ramp_rgb_t ramp_entry(ramp_sel_t s, logic [IDX_W-1:0] i);
        logic [IDX_W+1:0] pos;
        logic [1:0]       seg;
        logic [IDX_W+1:0] frac;
        logic [2:0]       sa, sb;
        logic [8:0]       chan;
        logic [23:0]      packed_rgb;
        pos = '0;
        case (s)
            RAMP_GREY:   pos = (IDX_W+2)'(i);
            RAMP_BWR:    pos = (IDX_W+2)'(i) << 1;
            RAMP_HEIGHT: pos = ((IDX_W+2)'(i) << 1) + (IDX_W+2)'(i);
            default:     pos = '0;
        endcase
        if (pos >= (IDX_W+2)'(3 * LAST_IDX))
            seg = 2'd3;
        else if (pos >= (IDX_W+2)'(2 * LAST_IDX))
            seg = 2'd2;
        else if (pos >= (IDX_W+2)'(LAST_IDX))
            seg = 2'd1;
        else
            seg = 2'd0;
        case (seg)
            2'd0:    frac = pos;
            2'd1:    frac = pos - (IDX_W+2)'(LAST_IDX);
            2'd2:    frac = pos - (IDX_W+2)'(2 * LAST_IDX);
            default: frac = pos - (IDX_W+2)'(3 * LAST_IDX);
        endcase
        sa = stop_rgb(s, seg);
        sb = stop_rgb(s, seg + 2'd1);
        packed_rgb = '0;
        for (int c = 0; c < 3; c++)
        begin
            chan = (sa[c] ? 9'(LAST_IDX) - 9'(frac) : 9'd0) + (sb[c] ? 9'(frac) : 9'd0);
            packed_rgb[c*8 +: 8] = chan[7:0];
        end
        return ramp_rgb_t'(packed_rgb);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
            rgb <= ramp_entry(sel, index);
    end

endmodule

`default_nettype wire

@@ design/point_color_mapper.sv @@
`default_nettype none

// Colours one point per clock. Each accepted word on points yields exactly one word on
// colors, in order, after operand prep (differences, then magnitudes), a numerator
// stage, nine restoring divide steps for the height index, the ramp table read and
// the output register. A stall on colors holds the whole pipeline and drops
// points.ready in the same cycle; otherwise one point is taken every cycle. Registers
// on cfg (0 colour mode, 1 z_min, 2 z_max) must be written only while the pipeline is
// empty; the block does not enforce this. cfg is always ready, other indexes ignored.
module point_color_mapper (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pcm_stream_if.sink     points,
    pcm_stream_if.source   colors,
    pcm_stream_if.sink     cfg
);
    import pcm_pkg::*;

    function automatic logic [7:0] scale_by_intensity(logic [7:0] c, logic [7:0] k);
        logic [15:0] y;
        logic [16:0] t;
        y = ({8'd0, c} * {8'd0, k}) + 16'd127;
        t = {1'b0, y} + 17'(y >> 8) + 17'd1;
        return t[15:8];
    endfunction

    color_mode_t               color_mode_reg;
    logic signed [Z_W-1:0]     z_min_reg, z_max_reg;
    logic [PIPE_DEPTH-1:0]     vld_reg;
    logic                      adv;

    side_t                     side_in, side_div, side_rom_reg;
    logic [IDX_W-1:0]          height_idx, rom_idx;
    ramp_sel_t                 rom_sel;
    ramp_rgb_t                 rom_rgb;
    color_t                    color_reg, color_next;

    assign adv          = !vld_reg[PIPE_DEPTH-1] || colors.ready;
    assign points.ready = adv;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= MODE_RESET;
            z_min_reg      <= Z_MIN_RESET;
            z_max_reg      <= Z_MAX_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_COLOR_MODE: color_mode_reg <= color_mode_t'(cfg.data.value[1:0]);
                CFG_Z_MIN:      z_min_reg      <= signed'(cfg.data.value);
                CFG_Z_MAX:      z_max_reg      <= signed'(cfg.data.value);
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], points.valid};
    end

    assign side_in = '{mode:      color_mode_reg,
                       intensity: points.data.intensity,
                       red:       points.data.red_in,
                       green:     points.data.green_in,
                       blue:      points.data.blue_in};

    pcm_height_div u_div (
        .clk      (clk),
        .en       (adv),
        .z_coord  (points.data.z_coord),
        .z_min    (z_min_reg),
        .z_max    (z_max_reg),
        .side_in  (side_in),
        .index    (height_idx),
        .side_out (side_div)
    );

    always_comb
    begin
        case (side_div.mode)
            MODE_GREY:
            begin
                rom_sel = RAMP_GREY;
                rom_idx = side_div.intensity;
            end
            MODE_BWR:
            begin
                rom_sel = RAMP_BWR;
                rom_idx = side_div.intensity;
            end
            MODE_HEIGHT:
            begin
                rom_sel = RAMP_HEIGHT;
                rom_idx = height_idx;
            end
            default:
            begin
                rom_sel = RAMP_GREY;
                rom_idx = '0;
            end
        endcase
    end

    pcm_ramp_rom u_rom (
        .clk   (clk),
        .en    (adv),
        .sel   (rom_sel),
        .index (rom_idx),
        .rgb   (rom_rgb)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_rom_reg <= side_div;
            color_reg    <= color_next;
        end
    end

    always_comb
    begin
        color_next.alpha_out = ALPHA_FULL;
        case (side_rom_reg.mode)
            MODE_RGB:
            begin
                color_next.red_out   = side_rom_reg.red;
                color_next.green_out = side_rom_reg.green;
                color_next.blue_out  = side_rom_reg.blue;
            end
            MODE_HEIGHT:
            begin
                color_next.red_out   = scale_by_intensity(rom_rgb.red, side_rom_reg.intensity);
                color_next.green_out = scale_by_intensity(rom_rgb.green,
                                                          side_rom_reg.intensity);
                color_next.blue_out  = scale_by_intensity(rom_rgb.blue, side_rom_reg.intensity);
            end
            default:
            begin
                color_next.red_out   = rom_rgb.red;
                color_next.green_out = rom_rgb.green;
                color_next.blue_out  = rom_rgb.blue;
            end
        endcase
    end

    assign colors.valid = vld_reg[PIPE_DEPTH-1];
    assign colors.data  = color_reg;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (colors.valid && !colors.ready) |-> !points.ready)
        else $error("input taken while output word stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (points.valid && points.ready) |=> vld_reg[0])
        else $error("accepted word missing from pipeline");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready && cfg.data.index == CFG_COLOR_MODE)
        |=> color_mode_reg == color_mode_t'($past(cfg.data.value[1:0])))
        else $error("colour mode write lost");
`endif

endmodule

`default_nettype wire
